[design/assert_macros.svh]
// assertion helpers used by the checker file sfd_checker
// every macro samples on clk and is held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold in the same cycle that the trigger is seen
`define CHK_SAME(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// property must hold in the cycle after the trigger
`define CHK_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

[design/sfd_pkg.sv]
package sfd_pkg;

	localparam logic [7:0] TAG_ESC   = 8'hF4;
	localparam logic [7:0] TAG_OPEN  = 8'hF5;
	localparam logic [7:0] TAG_CLOSE = 8'hFB;
	localparam logic [7:0] CLS_STAT  = 8'h66;
	localparam logic [7:0] DIR_UNIT  = 8'h01;
	localparam logic [7:0] DIR_CMD   = 8'h00;

	localparam int MIN_FRAME = 15;
	localparam int DIR_POS   = 2;
	localparam int CLS_POS   = 13;

	localparam logic [1:0] CAT_SHORT  = 2'd0;
	localparam logic [1:0] CAT_STATUS = 2'd1;
	localparam logic [1:0] CAT_CMD    = 2'd2;
	localparam logic [1:0] CAT_LINK   = 2'd3;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// up to two consecutive store bytes written per pushed byte
	typedef struct packed {
		logic       en0;
		logic       en1;
		logic [7:0] d0;
		logic [7:0] d1;
	} wr_t;

	// frame completion report for one pushed byte
	typedef struct packed {
		logic       done;
		logic [8:0] len;
		logic [7:0] dir;
		logic [7:0] cls;
		logic [1:0] cat;
	} report_t;

endpackage

[design/sfd_ram.sv]
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/sfd_parser.sv]
module sfd_parser #(
	parameter int STORE_BYTES = 256,
	localparam int FW = $clog2(STORE_BYTES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      byte_in,
	output sfd_pkg::wr_t    wr,
	output logic [FW-1:0]   wr_base,
	output sfd_pkg::report_t rep
);

	import sfd_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_OPENESC = 2'd1;
	localparam logic [1:0] ST_BODY    = 2'd2;
	localparam logic [1:0] ST_BODYESC = 2'd3;

	localparam logic [FW:0] STORE_X = (FW + 1)'(STORE_BYTES);

	logic [1:0]    state_q, state_nx;
	logic [FW-1:0] fill_q, fill_nx;
	logic [7:0]    dir_q, dir_nx;
	logic [7:0]    cls_q, cls_nx;
	logic [FW:0]   len_full;
	logic [FW-1:0] base_p1;
	logic          fill_ok, pair_ok, start, done;

	assign len_full = {1'b0, fill_q} + (FW + 1)'(2);
	assign fill_ok  = {1'b0, fill_q} < STORE_X;
	assign pair_ok  = len_full <= STORE_X;
	assign base_p1  = wr_base + FW'(1);

	always_comb begin
		state_nx = state_q;
		fill_nx  = fill_q;
		wr       = '0;
		wr_base  = fill_q;
		start    = 1'b0;
		done     = 1'b0;
		if (push) begin
			case (state_q)
				ST_IDLE: begin
					if (byte_in == TAG_ESC) state_nx = ST_OPENESC;
				end
				ST_OPENESC: begin
					if (byte_in == TAG_OPEN) start = 1'b1;
					else if (byte_in != TAG_ESC) state_nx = ST_IDLE;
				end
				ST_BODY: begin
					if (byte_in == TAG_ESC) begin
						state_nx = ST_BODYESC;
					end else if (fill_ok) begin
						wr.en0  = 1'b1;
						wr.d0   = byte_in;
						fill_nx = fill_q + FW'(1);
					end else begin
						state_nx = ST_IDLE;
					end
				end
				ST_BODYESC: begin
					if (byte_in == TAG_CLOSE) begin
						state_nx = ST_IDLE;
						if (pair_ok) begin
							wr.en0  = 1'b1;
							wr.en1  = 1'b1;
							wr.d0   = TAG_ESC;
							wr.d1   = TAG_CLOSE;
							fill_nx = FW'(len_full);
							done    = 1'b1;
						end
					end else if (byte_in == TAG_ESC) begin
						// escaped literal, dropped when the store is full
						state_nx = ST_BODY;
						if (fill_ok) begin
							wr.en0  = 1'b1;
							wr.d0   = TAG_ESC;
							fill_nx = fill_q + FW'(1);
						end
					end else if (byte_in == TAG_OPEN) begin
						start = 1'b1;
					end else begin
						state_nx = ST_BODY;
						if (pair_ok) begin
							wr.en0  = 1'b1;
							wr.en1  = 1'b1;
							wr.d0   = TAG_ESC;
							wr.d1   = byte_in;
							fill_nx = FW'(len_full);
						end
					end
				end
				default: state_nx = ST_IDLE;
			endcase
			if (start) begin
				wr.en0   = 1'b1;
				wr.en1   = 1'b1;
				wr.d0    = TAG_ESC;
				wr.d1    = TAG_OPEN;
				wr_base  = '0;
				fill_nx  = FW'(2);
				state_nx = ST_BODY;
			end
		end
	end

	// shadow copies of frame bytes 2 and 13, taken as they are written
	always_comb begin
		dir_nx = dir_q;
		cls_nx = cls_q;
		if (wr.en0 && wr_base == FW'(DIR_POS)) dir_nx = wr.d0;
		if (wr.en1 && base_p1 == FW'(DIR_POS)) dir_nx = wr.d1;
		if (wr.en0 && wr_base == FW'(CLS_POS)) cls_nx = wr.d0;
		if (wr.en1 && base_p1 == FW'(CLS_POS)) cls_nx = wr.d1;
	end

	always_comb begin
		rep = '0;
		if (done) begin
			rep.done = 1'b1;
			rep.len  = 9'(len_full);
			if (len_full >= (FW + 1)'(MIN_FRAME)) begin
				rep.dir = dir_nx;
				rep.cls = cls_nx;
				if (dir_nx == DIR_UNIT && cls_nx == CLS_STAT) rep.cat = CAT_STATUS;
				else if (dir_nx == DIR_CMD) rep.cat = CAT_CMD;
				else rep.cat = CAT_LINK;
			end else begin
				rep.cat = CAT_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			dir_q   <= '0;
			cls_q   <= '0;
		end else begin
			state_q <= state_nx;
			fill_q  <= fill_nx;
			dir_q   <= dir_nx;
			cls_q   <= cls_nx;
		end
	end

endmodule

[design/sfd_store.sv]
module sfd_store #(
	parameter int STORE_BYTES = 256,
	localparam int FW = $clog2(STORE_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sfd_pkg::wr_t  wr,
	input  logic [FW-1:0] wr_base,
	input  logic          rd_en,
	input  logic [7:0]    rd_index,
	output logic [7:0]    rd_data
);

	import sfd_pkg::*;

	// even and odd banks so both bytes of a pair land in the same cycle
	localparam int HALF = (STORE_BYTES + 1) / 2;
	localparam int AW   = $clog2(HALF);
	localparam int XW   = (AW + 1 > 8) ? AW + 1 : 8;

	logic [FW-1:0] a0, a1;
	logic          ev0, ev1;
	logic          we_e, we_o;
	logic [AW-1:0] wa_e, wa_o, ra;
	logic [7:0]    wd_e, wd_o, rd_e, rd_o;
	logic [XW-1:0] idx_x;
	logic          sel_q, ok_q;

	assign a0  = wr_base;
	assign a1  = wr_base + FW'(1);
	assign ev0 = wr.en0 && !a0[0];
	assign ev1 = wr.en1 && !a1[0];

	assign we_e = ev0 || ev1;
	assign wa_e = ev0 ? a0[AW:1] : a1[AW:1];
	assign wd_e = ev0 ? wr.d0 : wr.d1;
	assign we_o = (wr.en0 && a0[0]) || (wr.en1 && a1[0]);
	assign wa_o = (wr.en0 && a0[0]) ? a0[AW:1] : a1[AW:1];
	assign wd_o = (wr.en0 && a0[0]) ? wr.d0 : wr.d1;

	assign idx_x = XW'(rd_index);
	assign ra    = idx_x[AW:1];

	sfd_ram #(.WIDTH(8), .DEPTH(HALF)) u_even (
		.clk  (clk),
		.we   (we_e),
		.waddr(wa_e),
		.wdata(wd_e),
		.re   (rd_en),
		.raddr(ra),
		.rdata(rd_e)
	);

	sfd_ram #(.WIDTH(8), .DEPTH(HALF)) u_odd (
		.clk  (clk),
		.we   (we_o),
		.waddr(wa_o),
		.wdata(wd_o),
		.re   (rd_en),
		.raddr(ra),
		.rdata(rd_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			ok_q  <= 1'b0;
		end else if (rd_en) begin
			sel_q <= rd_index[0];
			ok_q  <= {24'd0, rd_index} < 32'(STORE_BYTES);
		end
	end

	assign rd_data = !ok_q ? 8'd0 : (sel_q ? rd_o : rd_e);

endmodule

[design/stuffed_frame_deframer.sv]
// channel  dir  tdata                                        tuser
// s_axis   in   byte_in[7:0], read_index[15:8]               action
// m_axis   out  frame_length[8:0], direction_byte[16:9],     frame_done
//               class_byte[24:17], category[26:25],
//               read_data[34:27], zero pad[39:35]
//
// one item per cycle while the output is not stalled; each result appears in the cycle after its transfer,
// registered in the result stage, with read data from the registered read port of the frame store banks
// the store is split into even and odd banks so both bytes of a pair write in the same cycle
// reset clears parser state and fill count at once; store contents are left
// undefined, so there is no clearing pass
// a held result blocks new transfers only while m_axis_tready is low
module stuffed_frame_deframer #(
	parameter int STORE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // byte_in, read_index
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // frame_length, direction_byte, class_byte,
	                                   // category, read_data, zero pad
	output logic        m_axis_tuser   // frame_done
);

	import sfd_pkg::*;

	localparam int FW = $clog2(STORE_BYTES + 1);

	logic          accept, push, rd_en;
	wr_t           wr;
	logic [FW-1:0] wr_base;
	report_t       rep, rep_s1;
	logic          valid_s1, rd_s1;
	logic [7:0]    store_rd;
	logic [7:0]    read_data;

	// output stage frees up in the same cycle its result is taken
	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept && (s_axis_tuser == ACT_PUSH);
	assign rd_en         = accept && (s_axis_tuser == ACT_READ);

	sfd_parser #(.STORE_BYTES(STORE_BYTES)) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.byte_in(s_axis_tdata[7:0]),
		.wr     (wr),
		.wr_base(wr_base),
		.rep    (rep)
	);

	// read data is held in the bank output registers until the next read
	sfd_store #(.STORE_BYTES(STORE_BYTES)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_base (wr_base),
		.rd_en   (rd_en),
		.rd_index(s_axis_tdata[15:8]),
		.rd_data (store_rd)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_s1    <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				rd_s1    <= s_axis_tuser == ACT_READ;
			end else if (m_axis_tready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rep_s1 <= rep;
		end
	end

	assign read_data     = rd_s1 ? store_rd : 8'd0;
	assign m_axis_tvalid = valid_s1;
	assign m_axis_tuser  = rep_s1.done;
	assign m_axis_tdata  = {5'd0, read_data, rep_s1.cat, rep_s1.cls, rep_s1.dir, rep_s1.len};

endmodule

[design/sfd_checker.sv]
`include "assert_macros.svh"

module sfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	import sfd_pkg::*;

	logic [8:0] len;
	logic [7:0] dir, cls;
	logic [1:0] cat;
	logic       s_xfer, m_hold, short_done;
	logic       frame_out, plain_out, short_ok, plain_ok;

	assign len        = m_axis_tdata[8:0];
	assign dir        = m_axis_tdata[16:9];
	assign cls        = m_axis_tdata[24:17];
	assign cat        = m_axis_tdata[26:25];
	assign s_xfer     = s_axis_tvalid && s_axis_tready;
	assign m_hold     = m_axis_tvalid && !m_axis_tready;
	assign frame_out  = m_axis_tvalid && m_axis_tuser;
	assign plain_out  = m_axis_tvalid && !m_axis_tuser;
	assign short_done = frame_out && len < 9'(MIN_FRAME);
	assign short_ok   = cat == CAT_SHORT && dir == 8'd0 && cls == 8'd0;
	assign plain_ok   = len == 9'd0 && cat == CAT_SHORT;

	`CHK_NEXT(a_hold_valid, m_hold, m_axis_tvalid, "result dropped while stalled")
	`CHK_NEXT(a_one_result, s_xfer, m_axis_tvalid, "no result after input transfer")
	`CHK_SAME(a_short_frame, short_done, short_ok, "short frame fields")
	`CHK_SAME(a_no_done, plain_out, plain_ok, "report without frame")
	`CHK_SAME(a_min_len, frame_out, len >= 9'd4, "frame shorter than its tags")

endmodule

bind stuffed_frame_deframer sfd_checker u_sfd_checker (.*);
